[hw/rtl/pdvu_pkg.sv]
// Package: item types, register indexes and fixed-point helpers for the drag update.
`default_nettype none
package pdvu_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned SQRT_STEPS = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DRAG_COEFF   = 2'd0,
    REG_FLUID_DENS   = 2'd1,
    REG_QUAD_MODE    = 2'd2,
    REG_UNUSED       = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] inverse_mass;
    logic        [31:0] particle_size;
    logic        [31:0] time_step;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_vel_z;
    logic               passed_through;
  } out_item_t;

  // Per-item data carried alongside the square root.
  typedef struct packed {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic        [31:0] im;
    logic        [31:0] dt;
    logic        [31:0] q2;
    logic        [31:0] lin;
    logic               pass_im;
  } side_t;

  // Unsigned fixed-point product, saturated to 32 bits.
  function automatic logic [31:0] mulq(input logic [31:0] a, input logic [31:0] b,
                                       input int unsigned fb);
    logic [63:0] p;
    p = (64'(a) * 64'(b)) >> fb;
    mulq = (p[63:32] != 32'd0) ? 32'hFFFF_FFFF : p[31:0];
  endfunction

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = 66'sh0_7FFF_FFFF;
    lo = -66'sh0_8000_0000;
    if (x > hi) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (x < lo) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = x[31:0];
    end
  endfunction

endpackage
`default_nettype wire

[hw/rtl/pdvu_front.sv]
// Front stages: squared speed and the speed-independent drag products.
`default_nettype none
module pdvu_front #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_vld,
  input  wire pdvu_pkg::in_item_t in_item,
  input  wire logic [31:0]      drag_coeff,
  input  wire logic [31:0]      fluid_dens,
  output logic                  out_vld,
  output logic [63:0]           sumsq,
  output pdvu_pkg::side_t       side
);

  logic               s1_vld;
  logic [63:0]        sq_x, sq_y, sq_z;
  logic [31:0]        p1, area, q1;
  pdvu_pkg::in_item_t s1_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld  <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      s1_vld  <= in_vld;
      out_vld <= s1_vld;
    end
  end

  // Stage 1: squares and first products.
  always_ff @(posedge clk) begin
    sq_x    <= 64'(in_item.vel_x) * 64'(in_item.vel_x);
    sq_y    <= 64'(in_item.vel_y) * 64'(in_item.vel_y);
    sq_z    <= 64'(in_item.vel_z) * 64'(in_item.vel_z);
    p1      <= pdvu_pkg::mulq(drag_coeff, in_item.time_step, FRAC_BITS);
    area    <= pdvu_pkg::mulq(in_item.particle_size, in_item.particle_size, FRAC_BITS);
    q1      <= pdvu_pkg::mulq(fluid_dens, drag_coeff, FRAC_BITS);
    s1_item <= in_item;
  end

  // Stage 2: sum of squares, area term and linear factor.
  always_ff @(posedge clk) begin
    sumsq        <= sq_x + sq_y + sq_z;
    side.vx      <= s1_item.vel_x;
    side.vy      <= s1_item.vel_y;
    side.vz      <= s1_item.vel_z;
    side.im      <= s1_item.inverse_mass;
    side.dt      <= s1_item.time_step;
    side.q2      <= pdvu_pkg::mulq(q1, area, FRAC_BITS);
    side.lin     <= pdvu_pkg::mulq(p1, s1_item.inverse_mass, FRAC_BITS);
    side.pass_im <= (s1_item.inverse_mass <= 32'sd0);
  end

endmodule
`default_nettype wire

[hw/rtl/pdvu_isqrt.sv]
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module pdvu_isqrt (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_vld,
  input  wire logic [63:0]     radicand,
  input  wire pdvu_pkg::side_t in_side,
  output logic                 out_vld,
  output logic [31:0]          root,
  output pdvu_pkg::side_t      out_side
);

  localparam int unsigned N = pdvu_pkg::SQRT_STEPS;

  logic            vld  [0:N];
  logic [63:0]     rad  [0:N];
  logic [33:0]     rem  [0:N];
  logic [31:0]     rt   [0:N];
  pdvu_pkg::side_t sd   [0:N];

  assign vld[0] = in_vld;
  assign rad[0] = radicand;
  assign rem[0] = 34'd0;
  assign rt[0]  = 32'd0;
  assign sd[0]  = in_side;

  for (genvar i = 0; i < N; i++) begin : g_step
    logic [35:0] r_sh;
    logic [35:0] trial;
    logic [35:0] diff;
    logic        take;

    always_comb begin
      r_sh  = {rem[i], rad[i][63:62]};
      trial = {2'b00, rt[i], 2'b01};
      diff  = r_sh - trial;
      take  = (r_sh >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      rad[i+1] <= {rad[i][61:0], 2'b00};
      rem[i+1] <= take ? diff[33:0] : r_sh[33:0];
      rt[i+1]  <= {rt[i][30:0], take};
      sd[i+1]  <= sd[i];
    end
  end

  assign out_vld  = vld[N];
  assign root     = rt[N];
  assign out_side = sd[N];

endmodule
`default_nettype wire

[hw/rtl/pdvu_back.sv]
// Back stages: speed-dependent products, scale, per-axis multiply and saturation.
`default_nettype none
module pdvu_back #(
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned SPEED_FLOOR = 7
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_vld,
  input  wire logic [31:0]     speed,
  input  wire pdvu_pkg::side_t in_side,
  input  wire logic            quad_mode,
  output logic                 out_vld,
  output pdvu_pkg::out_item_t  out_item
);

  logic               t1_vld, t2_vld, t3_vld, t4_vld;
  pdvu_pkg::side_t    t1_sd, t2_sd, t3_sd;
  logic [31:0]        q3, q4;
  logic               t1_pass, t2_pass, t3_pass, t4_pass;
  logic signed [33:0] scale;
  logic signed [31:0] t4_vx, t4_vy, t4_vz;
  logic signed [65:0] prod_x, prod_y, prod_z;
  logic [31:0]        f;

  always_ff @(posedge clk) begin
    if (rst) begin
      t1_vld  <= 1'b0;
      t2_vld  <= 1'b0;
      t3_vld  <= 1'b0;
      t4_vld  <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      t1_vld  <= in_vld;
      t2_vld  <= t1_vld;
      t3_vld  <= t2_vld;
      t4_vld  <= t3_vld;
      out_vld <= t4_vld;
    end
  end

  always_comb begin
    f = pdvu_pkg::mulq(q4, t2_sd.im, FRAC_BITS);
    if (quad_mode) begin
      f = {1'b0, f[31:1]};
    end else begin
      f = t2_sd.lin;
    end
  end

  always_ff @(posedge clk) begin
    // T1: times speed, decide pass-through
    q3      <= pdvu_pkg::mulq(in_side.q2, speed, FRAC_BITS);
    t1_pass <= in_side.pass_im || (speed < 32'(SPEED_FLOOR));
    t1_sd   <= in_side;
    // T2: times dt
    q4      <= pdvu_pkg::mulq(q3, t1_sd.dt, FRAC_BITS);
    t2_pass <= t1_pass;
    t2_sd   <= t1_sd;
    // T3: times inverse mass, form scale
    scale   <= $signed(34'(1) << FRAC_BITS) - $signed({2'b00, f});
    t3_pass <= t2_pass;
    t3_sd   <= t2_sd;
    // T4: per-axis products
    prod_x  <= 66'(t3_sd.vx) * 66'(scale);
    prod_y  <= 66'(t3_sd.vy) * 66'(scale);
    prod_z  <= 66'(t3_sd.vz) * 66'(scale);
    t4_vx   <= t3_sd.vx;
    t4_vy   <= t3_sd.vy;
    t4_vz   <= t3_sd.vz;
    t4_pass <= t3_pass;
    // T5: floor shift and clamp, or pass the input velocity through
    out_item.new_vel_x      <= t4_pass ? t4_vx : pdvu_pkg::sat32(prod_x >>> FRAC_BITS);
    out_item.new_vel_y      <= t4_pass ? t4_vy : pdvu_pkg::sat32(prod_y >>> FRAC_BITS);
    out_item.new_vel_z      <= t4_pass ? t4_vz : pdvu_pkg::sat32(prod_z >>> FRAC_BITS);
    out_item.passed_through <= t4_pass;
  end

endmodule
`default_nettype wire

[hw/rtl/particle_drag_velocity_update_top.sv]
// Top level of the particle drag velocity update pipeline.
//
//  channel   signals                         handshake
//  --------  ------------------------------  --------------------------------
//  input     start, busy, item               taken when start && !busy
//  result    result_valid, result            one-cycle strobe, no back-pressure
//  config    cfg_we, cfg_addr, cfg_wdata     written when cfg_we is high
//
// One item enters every cycle that start is high; busy is tied low. An
// accepted item passes through 2 front stages, 32 square-root stages
// (one root bit each) and 5 back stages on its way to the result.
// Synchronous reset clears the valid bits and restores register defaults.
// The receiver cannot stall, so no stage ever holds.
`default_nettype none
module particle_drag_velocity_update_top #(
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned SPEED_FLOOR = 7
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire pdvu_pkg::in_item_t                  item,
  output logic                                     result_valid,
  output pdvu_pkg::out_item_t                      result,
  input  wire logic                                cfg_we,
  input  wire logic [pdvu_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  wire logic [pdvu_pkg::DATA_W-1:0]         cfg_wdata
);

  logic [31:0]     drag_coeff;
  logic [31:0]     fluid_dens;
  logic            quad_mode;

  logic            fr_vld;
  logic [63:0]     fr_sumsq;
  pdvu_pkg::side_t fr_side;
  logic            sq_vld;
  logic [31:0]     sq_root;
  pdvu_pkg::side_t sq_side;

  // Fully pipelined: never refuse an item.
  assign busy = 1'b0;

  // Drag registers; writes to the unused index drop.
  always_ff @(posedge clk) begin
    if (rst) begin
      drag_coeff <= 32'd65536;
      fluid_dens <= 32'd80282;
      quad_mode  <= 1'b1;
    end else if (cfg_we) begin
      unique case (pdvu_pkg::cfg_reg_t'(cfg_addr))
        pdvu_pkg::REG_DRAG_COEFF: drag_coeff <= cfg_wdata;
        pdvu_pkg::REG_FLUID_DENS: fluid_dens <= cfg_wdata;
        pdvu_pkg::REG_QUAD_MODE:  quad_mode  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  pdvu_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_vld    (start && !busy),
    .in_item   (item),
    .drag_coeff(drag_coeff),
    .fluid_dens(fluid_dens),
    .out_vld   (fr_vld),
    .sumsq     (fr_sumsq),
    .side      (fr_side)
  );

  pdvu_isqrt u_isqrt (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (fr_vld),
    .radicand(fr_sumsq),
    .in_side (fr_side),
    .out_vld (sq_vld),
    .root    (sq_root),
    .out_side(sq_side)
  );

  pdvu_back #(.FRAC_BITS(FRAC_BITS), .SPEED_FLOOR(SPEED_FLOOR)) u_back (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (sq_vld),
    .speed    (sq_root),
    .in_side  (sq_side),
    .quad_mode(quad_mode),
    .out_vld  (result_valid),
    .out_item (result)
  );

endmodule
`default_nettype wire

[hw/rtl/pdvu_checker.sv]
// Port-level checker for the drag update pipeline, with its bind.
`default_nettype none
module pdvu_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                start,
  input wire logic                busy,
  input wire pdvu_pkg::in_item_t  item,
  input wire logic                result_valid,
  input wire pdvu_pkg::out_item_t result
);

  localparam int unsigned LAT = 39;

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  a_item_gives_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##39 result_valid)
    else $error("accepted item produced no result");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(start && !busy, LAT))
    else $error("result without an item");

  a_immovable_pass: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.inverse_mass <= 32'sd0) |-> ##39
      (result.passed_through && result.new_vel_x == $past(item.vel_x, LAT)))
    else $error("immovable particle not passed through");

endmodule

bind particle_drag_velocity_update_top pdvu_checker u_pdvu_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .item        (item),
  .result_valid(result_valid),
  .result      (result)
);
`default_nettype wire

[tb/particle_drag_velocity_update_top_tb.sv]
// Testbench for the particle drag velocity update pipeline: directed and random items, self-checking.
`timescale 1ns / 100ps
`default_nettype none

// Holds the register copy, predicts the damped velocity and keeps the expected items in order.
class drag_scoreboard;
  logic [31:0] drag_k;
  logic [31:0] density;
  logic        quad;
  pdvu_pkg::out_item_t pending_vel[$];
  int unsigned errors;

  function new();
    drag_k = 32'd65536;
    density = 32'd80282;
    quad = 1'b1;
    errors = 0;
  endfunction

  function void write_reg(pdvu_pkg::cfg_reg_t idx, logic [31:0] val);
    case (idx)
      pdvu_pkg::REG_DRAG_COEFF: drag_k = val;
      pdvu_pkg::REG_FLUID_DENS: density = val;
      pdvu_pkg::REG_QUAD_MODE:  quad = val[0];
      default: ;
    endcase
  endfunction

  // Unsigned Q16.16 product, floored, saturated to 32 bits.
  function logic [31:0] qmul(logic [31:0] a, logic [31:0] b);
    logic [63:0] p;
    p = ({32'd0, a} * {32'd0, b}) >> 16;
    return (p[63:32] != 0) ? 32'hFFFF_FFFF : p[31:0];
  endfunction

  // Floor square root of a 64-bit value, bit by bit.
  function logic [63:0] root64(logic [63:0] x);
    logic [63:0] rem;
    logic [63:0] r;
    logic [63:0] b;
    rem = x;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (rem >= r + b) begin
        rem = rem - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function logic signed [31:0] damp(logic signed [31:0] v, logic signed [63:0] scale);
    logic signed [127:0] prod;
    logic signed [127:0] sh;
    prod = 128'(v) * 128'(scale);
    sh = prod >>> 16;
    if (sh > 128'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (sh < -128'sh8000_0000) return 32'sh8000_0000;
    return sh[31:0];
  endfunction

  function void note_item(pdvu_pkg::in_item_t it);
    pdvu_pkg::out_item_t e;
    logic [63:0] sumsq;
    logic [63:0] spd;
    logic [31:0] t;
    logic [31:0] f;
    logic signed [63:0] scale;
    sumsq = 64'(64'(it.vel_x) * 64'(it.vel_x)) + 64'(64'(it.vel_y) * 64'(it.vel_y))
          + 64'(64'(it.vel_z) * 64'(it.vel_z));
    spd = root64(sumsq);
    e.new_vel_x = it.vel_x;
    e.new_vel_y = it.vel_y;
    e.new_vel_z = it.vel_z;
    e.passed_through = 1'b1;
    if (it.inverse_mass > 0 && spd >= 7) begin
      if (quad) begin
        t = qmul(density, drag_k);
        t = qmul(t, qmul(it.particle_size, it.particle_size));
        // speed is under 2^32 here, so its low word is the whole value
        t = qmul(t, spd[31:0]);
        t = qmul(t, it.time_step);
        t = qmul(t, it.inverse_mass);
        f = t >> 1;
      end else begin
        f = qmul(qmul(drag_k, it.time_step), it.inverse_mass);
      end
      scale = 64'sd65536 - $signed({32'd0, f});
      e.new_vel_x = damp(it.vel_x, scale);
      e.new_vel_y = damp(it.vel_y, scale);
      e.new_vel_z = damp(it.vel_z, scale);
      e.passed_through = 1'b0;
    end
    pending_vel.push_back(e);
  endfunction

  function void check_result(pdvu_pkg::out_item_t got);
    pdvu_pkg::out_item_t e;
    if (pending_vel.size() == 0) begin
      $error("unexpected result %h", got);
      errors++;
      return;
    end
    e = pending_vel.pop_front();
    if (got.new_vel_x !== e.new_vel_x) begin
      $error("new_vel_x exp %h got %h", e.new_vel_x, got.new_vel_x); errors++;
    end
    if (got.new_vel_y !== e.new_vel_y) begin
      $error("new_vel_y exp %h got %h", e.new_vel_y, got.new_vel_y); errors++;
    end
    if (got.new_vel_z !== e.new_vel_z) begin
      $error("new_vel_z exp %h got %h", e.new_vel_z, got.new_vel_z); errors++;
    end
    if (got.passed_through !== e.passed_through) begin
      $error("passed_through exp %b got %b", e.passed_through, got.passed_through); errors++;
    end
  endfunction
endclass

module particle_drag_velocity_update_top_tb;

  localparam int LATENCY = 39;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  pdvu_pkg::in_item_t item = '0;
  logic result_valid;
  pdvu_pkg::out_item_t result;
  logic cfg_we = 1'b0;
  logic [pdvu_pkg::CFG_IDX_W-1:0] cfg_addr = '0;
  logic [pdvu_pkg::DATA_W-1:0] cfg_wdata = '0;

  drag_scoreboard vel_board = new();
  int idle_pct = 0;

  always #1 clk = ~clk;

  particle_drag_velocity_update_top u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .result_valid(result_valid), .result(result),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  // Sample accepted inputs and results at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) vel_board.note_item(item);
      if (result_valid) vel_board.check_result(result);
    end
  end

  // Idle a random number of cycles, then present one item and hold it until taken.
  // Start stays high afterwards so the next item can follow with no gap.
  task automatic send_item(pdvu_pkg::in_item_t it);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    item <= it;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // Drain the pipeline, then write one register while idle.
  task automatic write_reg(pdvu_pkg::cfg_reg_t idx, logic [31:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    vel_board.write_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Drop start and wait until every expected result is back.
  task automatic drain();
    start <= 1'b0;
    while (vel_board.pending_vel.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  function automatic logic [31:0] rnd_q(int mode);
    // Mix values up to two, small values up to a quarter and full-range bits.
    case (mode)
      0: return $urandom_range(32'h0002_0000);
      1: return $urandom_range(32'h0000_4000);
      default: return $urandom;
    endcase
  endfunction

  function automatic pdvu_pkg::in_item_t rnd_item();
    pdvu_pkg::in_item_t it;
    int shape;
    shape = $urandom_range(9);
    it.vel_x = (shape < 2) ? $urandom : $signed(rnd_q(0)) - 32'sh0001_0000;
    it.vel_y = (shape < 2) ? $urandom : $signed(rnd_q(0)) - 32'sh0001_0000;
    it.vel_z = (shape < 2) ? $urandom : $signed(rnd_q(0)) - 32'sh0001_0000;
    if (shape == 3) begin
      it.vel_x = $urandom_range(4) - 2; it.vel_y = $urandom_range(4) - 2;
      it.vel_z = $urandom_range(4) - 2;
    end
    it.inverse_mass = (shape == 4) ? $urandom : $signed(rnd_q(0));
    it.particle_size = (shape == 5) ? $urandom : rnd_q(0);
    it.time_step = (shape == 6) ? $urandom : rnd_q(1);
    return it;
  endfunction

  task automatic directed();
    pdvu_pkg::in_item_t it;
    it = '{32'sh0001_0000, 32'sh0002_0000, -32'sh0003_0000, 32'sh0001_0000,
           32'h0001_0000, 32'h0000_1000};
    send_item(it);
    it.inverse_mass = 0; send_item(it);                    // immovable
    it.inverse_mass = 32'sh8000_0000; send_item(it);       // negative inverse mass
    it = '{32'sd4, 32'sd3, 32'sd0, 32'sh0001_0000, 32'h0001_0000, 32'h0001_0000};
    send_item(it);                                         // speed under floor
    it.vel_x = 32'sd7; it.vel_y = 0; send_item(it);        // speed at floor
    it = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
           32'hFFFF_FFFF, 32'hFFFF_FFFF};
    send_item(it);                                         // extremes, saturation
    it = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sd1, 32'd0, 32'd0};
    send_item(it);
    it = '{32'shFFFF_FFFF, 32'sd0, 32'sd1, 32'sh0000_8000, 32'h0000_0001, 32'h0000_0001};
    send_item(it);
    it = '{32'sh0010_0000, -32'sh0010_0000, 32'sh0001_0000, 32'sh0004_0000,
           32'h0003_0000, 32'h0002_0000};
    send_item(it);                                         // factor above one reverses v
  endtask

  task automatic random_phase(int n, int pct);
    idle_pct = pct;
    repeat (n) send_item(rnd_item());
    idle_pct = 0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    directed();
    write_reg(pdvu_pkg::REG_QUAD_MODE, 32'd0);
    directed();
    write_reg(pdvu_pkg::REG_DRAG_COEFF, 32'hFFFF_FFFF);
    write_reg(pdvu_pkg::REG_UNUSED, 32'h1234_5678);       // ignored index
    random_phase(120, 0);
    write_reg(pdvu_pkg::REG_QUAD_MODE, 32'hFFFF_FFFF);
    write_reg(pdvu_pkg::REG_FLUID_DENS, 32'hFFFF_FFFF);
    directed();
    random_phase(120, 83);
    write_reg(pdvu_pkg::REG_DRAG_COEFF, 32'd0);
    write_reg(pdvu_pkg::REG_FLUID_DENS, 32'd0);
    random_phase(80, 37);
    write_reg(pdvu_pkg::REG_DRAG_COEFF, 32'h0001_0000);
    write_reg(pdvu_pkg::REG_FLUID_DENS, 32'd80282);
    random_phase(250, 0);
    write_reg(pdvu_pkg::REG_QUAD_MODE, 32'hFFFF_FFFE);
    write_reg(pdvu_pkg::REG_DRAG_COEFF, $urandom);
    write_reg(pdvu_pkg::REG_FLUID_DENS, $urandom_range(32'h0004_0000));
    random_phase(200, 83);
    write_reg(pdvu_pkg::REG_QUAD_MODE, 32'd1);
    random_phase(150, 37);
    drain();
    if (vel_board.errors == 0 && vel_board.pending_vel.size() == 0) begin
      $display("particle_drag_velocity_update_top verification clean");
    end else begin
      if (vel_board.pending_vel.size() != 0)
        $error("%0d results never arrived", vel_board.pending_vel.size());
      $display("particle_drag_velocity_update_top verification failed");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #400000;
    $display("particle_drag_velocity_update_top verification failed");
    $finish;
  end
endmodule
`default_nettype wire
